// ===== rtl/sample_aes_decryptor_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sample AES decryptor
// Shared concurrent assertion forms; every use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_AES_DECRYPTOR_UNIT_DEFINES_SVH
`define SAMPLE_AES_DECRYPTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SADEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SADEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sadec_pkg.sv =====
// ----------------------------------------------------------------------------
// sadec_pkg
// Types, constants and AES helper functions for the sample AES decryptor.
// ----------------------------------------------------------------------------
package sadec_pkg;

  localparam int VIDEO_LEAD_DEF  = 32;
  localparam int AUDIO_LEAD_DEF  = 16;
  localparam int CLEAR_RUN_DEF   = 144;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int ROUNDS          = 10;
  localparam int LEAD_W          = 9;

  localparam logic [2:0] REG_KEY_VALID = 3'd0;
  localparam logic [2:0] REG_KEY_HIGH  = 3'd1;
  localparam logic [2:0] REG_KEY_LOW   = 3'd2;
  localparam logic [2:0] REG_IV_HIGH   = 3'd3;
  localparam logic [2:0] REG_IV_LOW    = 3'd4;

  localparam logic [7:0] ESC_BYTE  = 8'h03;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef logic [0:15][7:0] blk_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        frame_kind;
    logic [3:0]  header_size;
    logic [15:0] frame_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic       was_decrypted;
  } out_t;

  typedef struct packed {
    blk_t       data;
    logic [4:0] cnt;
    logic       dec;
    logic       hx;
    logic [7:0] xb;
    logic       last;
    logic       restart;
  } q_t;

  localparam logic [2047:0] SBOX_BITS = 2048'h637c777bf26b6fc53001672bfed7ab76_ca82c97dfa5947f0add4a2af9ca472c0_b7fd9326363ff7cc34a5e5f171d83115_04c723c31896059a071280e2eb27b275_09832c1a1b6e5aa0523bd6b329e32f84_53d100ed20fcb15b6acbbe394a4c58cf_d0efaafb434d338545f9027f503c9fa8_51a3408f929d38f5bcb6da2110fff3d2_cd0c13ec5f974417c4a77e3d645d1973_60814fdc222a908846eeb814de5e0bdb_e0323a0a4906245cc2d3ac629195e479_e7c8376d8dd54ea96c56f4ea657aae08_ba78252e1ca6b4c6e8dd741f4bbd8b8a_703eb5664803f60e613557b986c11d9e_e1f8981169d98e949b1e87e9ce5528df_8ca1890dbfe6426841992d0fb054bb16;

  function automatic logic [2047:0] build_inv();
    logic [2047:0] t;
    logic [7:0]    s;
    t = '0;
    for (int i = 0; i < 256; i++) begin
      s = SBOX_BITS[2047-8*i -: 8];
      t[2047-8*int'(s) -: 8] = 8'(i);
    end
    return t;
  endfunction

  localparam logic [2047:0] INV_BITS = build_inv();

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_BITS[11'(2047 - 8*int'(x)) -: 8];
  endfunction

  function automatic logic [7:0] isbox(input logic [7:0] x);
    return INV_BITS[11'(2047 - 8*int'(x)) -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t inv_shift_sub(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r+4*c] = isbox(s[r+4*((c-r+4)%4)]);
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t t;
    logic [3:0][7:0] a, x2, x4, x8, m9, m11, m13, m14;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]   = s[4*c+j];
        x2[j]  = xtime(a[j]);
        x4[j]  = xtime(x2[j]);
        x8[j]  = xtime(x4[j]);
        m9[j]  = x8[j] ^ a[j];
        m11[j] = x8[j] ^ x2[j] ^ a[j];
        m13[j] = x8[j] ^ x4[j] ^ a[j];
        m14[j] = x8[j] ^ x4[j] ^ x2[j];
      end
      t[4*c]   = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[4*c+1] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[4*c+2] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[4*c+3] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

endpackage

// ===== rtl/sadec_keys.sv =====
// ----------------------------------------------------------------------------
// sadec_keys
// Iterative AES-128 key expansion, one round key per cycle, and key table.
// ----------------------------------------------------------------------------
module sadec_keys
  import sadec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  input  logic [3:0]  rd_idx,
  output blk_t        rd_key,
  output logic        busy
);

  blk_t       rk [ROUNDS+1];
  blk_t       prev;
  blk_t       nxt;
  logic [7:0] rcon;
  logic [3:0] rnd;
  logic       ld;
  logic       run;
  logic       ld_go;
  logic       step;

  assign ld_go  = ld && !start;
  assign step   = run && !start && !ld;
  assign busy   = ld || run;
  assign rd_key = rk[rd_idx];

  always_comb begin
    nxt[0] = prev[0] ^ sbox(prev[13]) ^ rcon;
    nxt[1] = prev[1] ^ sbox(prev[14]);
    nxt[2] = prev[2] ^ sbox(prev[15]);
    nxt[3] = prev[3] ^ sbox(prev[12]);
    for (int i = 4; i < 16; i++) begin
      nxt[i] = prev[i] ^ nxt[i-4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ld  <= 1'b1;
      run <= 1'b0;
      rnd <= '0;
    end else if (start) begin
      ld  <= 1'b1;
      run <= 1'b0;
    end else if (ld) begin
      ld  <= 1'b0;
      run <= 1'b1;
      rnd <= 4'd1;
    end else if (run) begin
      rnd <= rnd + 4'd1;
      if (rnd == 4'(ROUNDS)) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_go) begin
      rk[0] <= blk_t'({key_high, key_low});
      prev  <= blk_t'({key_high, key_low});
      rcon  <= 8'h01;
    end else if (step) begin
      rk[rnd] <= nxt;
      prev    <= nxt;
      rcon    <= xtime(rcon);
    end
  end

endmodule

// ===== rtl/sadec_front.sv =====
// ----------------------------------------------------------------------------
// sadec_front
// Frame parser: escape removal, lead and pattern tracking, block gathering.
// ----------------------------------------------------------------------------
module sadec_front
  import sadec_pkg::*;
#(
  parameter int VIDEO_LEAD = VIDEO_LEAD_DEF,
  parameter int AUDIO_LEAD = AUDIO_LEAD_DEF,
  parameter int CLEAR_RUN  = CLEAR_RUN_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic acc,
  input  in_t  item,
  input  logic key_valid,
  output logic push,
  output q_t   entry
);

  logic              enc, aud, pend;
  logic [LEAD_W-1:0] lead, pos;
  logic [7:0]        pat;
  logic [4:0]        held;
  logic [1:0]        zr;
  blk_t              blk;

  logic              enc_next, aud_next, rst_w, keep;
  logic [LEAD_W-1:0] lead_next, pos_next;
  logic [7:0]        pat_next;
  logic [8:0]        pat_inc;
  logic [4:0]        held_next;
  logic [1:0]        zr_next;
  blk_t              blk_next;
  logic [7:0]        b;

  assign b = item.data_byte;

  always_comb begin
    enc_next  = enc;
    aud_next  = aud;
    lead_next = lead;
    pos_next  = pos;
    pat_next  = pat;
    held_next = held;
    zr_next   = zr;
    blk_next  = blk;
    rst_w     = pend;
    keep      = 1'b1;
    pat_inc   = '0;
    if (item.first_byte) begin
      aud_next  = item.frame_kind;
      enc_next  = key_valid && (item.frame_kind ||
                  ({1'b0, item.frame_length} > 17'(VIDEO_LEAD + 16)));
      lead_next = item.frame_kind ?
                  LEAD_W'(item.header_size) + LEAD_W'(AUDIO_LEAD) : LEAD_W'(VIDEO_LEAD);
      pos_next  = '0;
      pat_next  = '0;
      held_next = '0;
      zr_next   = '0;
      rst_w     = 1'b1;
    end
    entry         = '0;
    entry.xb      = b;
    entry.last    = item.last_byte;
    entry.restart = rst_w;
    if (!enc_next) begin
      entry.hx = 1'b1;
    end else begin
      if (!aud_next) begin
        if (zr_next == 2'd2 && b == ESC_BYTE) begin
          keep    = 1'b0;
          zr_next = '0;
        end else if (b == ZERO_BYTE) begin
          if (zr_next != 2'd2) zr_next = zr_next + 2'd1;
        end else begin
          zr_next = '0;
        end
      end
      if (keep) begin
        if (pos_next < lead_next) begin
          entry.hx = 1'b1;
          pos_next = pos_next + LEAD_W'(1);
        end else if (aud_next) begin
          blk_next[held_next[3:0]] = b;
          held_next = held_next + 5'd1;
          if (held_next == 5'd16) begin
            entry.data = blk_next;
            entry.cnt  = 5'd16;
            entry.dec  = 1'b1;
            held_next  = '0;
          end
        end else if (pat_next == 8'd0) begin
          if (held_next != 5'd16) begin
            blk_next[held_next[3:0]] = b;
            held_next = held_next + 5'd1;
          end else begin
            entry.data = blk_next;
            entry.cnt  = 5'd16;
            entry.dec  = 1'b1;
            entry.hx   = 1'b1;
            held_next  = '0;
            pat_next   = (CLEAR_RUN <= 1) ? 8'd0 : 8'd1;
          end
        end else begin
          entry.hx = 1'b1;
          pat_inc  = {1'b0, pat_next} + 9'd1;
          pat_next = (pat_inc >= 9'(CLEAR_RUN)) ? 8'd0 : pat_inc[7:0];
        end
      end
    end
    if (item.last_byte) begin
      if (enc_next && !entry.dec) begin
        entry.cnt  = held_next;
        entry.data = blk_next;
      end
      held_next = '0;
      enc_next  = 1'b0;
    end
    push = acc && (entry.hx || entry.dec || item.last_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc  <= 1'b0;
      aud  <= 1'b0;
      pend <= 1'b0;
      lead <= LEAD_W'(VIDEO_LEAD);
      pos  <= '0;
      pat  <= '0;
      held <= '0;
      zr   <= '0;
    end else if (acc) begin
      enc  <= enc_next;
      aud  <= aud_next;
      pend <= push ? 1'b0 : rst_w;
      lead <= lead_next;
      pos  <= pos_next;
      pat  <= pat_next;
      held <= held_next;
      zr   <= zr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) blk <= blk_next;
  end

endmodule

// ===== rtl/sadec_fifo.sv =====
// ----------------------------------------------------------------------------
// sadec_fifo
// Short command queue between the frame parser and the block engine.
// ----------------------------------------------------------------------------
`include "sample_aes_decryptor_unit_defines.svh"

module sadec_fifo
  import sadec_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  q_t   wdata,
  input  logic pop,
  output q_t   rdata,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      if (push && !pop) cnt <= cnt + CW'(1);
      else if (pop && !push) cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  `SADEC_ASSERT_NOW(a_push_room, push, !full, "push into full queue")
  `SADEC_ASSERT_NOW(a_pop_data, pop, !empty, "pop from empty queue")
  `SADEC_ASSERT_NOW(a_cnt_range, 1'b1, cnt <= CW'(DEPTH), "queue count out of range")

endmodule

// ===== rtl/sadec_back.sv =====
// ----------------------------------------------------------------------------
// sadec_back
// Block engine: iterative AES-128 inverse rounds, CBC chain and byte output.
// ----------------------------------------------------------------------------
`include "sample_aes_decryptor_unit_defines.svh"

module sadec_back
  import sadec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  q_t          q_data,
  output logic        pop,
  input  logic [63:0] iv_high,
  input  logic [63:0] iv_low,
  output logic [3:0]  rk_idx,
  input  blk_t        rk,
  output out_t        result,
  output logic        result_valid,
  input  logic        result_ready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state;
  logic [3:0] rcnt;
  blk_t       st, cipher, chain, data;
  logic [4:0] rem;
  logic [3:0] idx;
  logic       dec, hx, last;
  logic [7:0] xb;
  logic       slot, fin;
  out_t       o_next;

  assign pop    = (state == S_IDLE) && !q_empty;
  assign rk_idx = (state == S_IDLE) ? 4'(ROUNDS) : rcnt;
  assign slot   = !result_valid || result_ready;
  assign fin    = (rem == 5'd1 && !hx) || (rem == 5'd0);

  always_comb begin
    o_next = '0;
    if (rem != 5'd0) begin
      o_next.out_byte      = data[idx];
      o_next.out_valid     = 1'b1;
      o_next.was_decrypted = dec;
      o_next.out_last      = last && rem == 5'd1 && !hx;
    end else if (hx) begin
      o_next.out_byte  = xb;
      o_next.out_valid = 1'b1;
      o_next.out_last  = last;
    end else begin
      o_next.out_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rcnt         <= '0;
      rem          <= '0;
      idx          <= '0;
      hx           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (slot && state != S_EMIT) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            rem   <= q_data.cnt;
            idx   <= '0;
            hx    <= q_data.hx;
            rcnt  <= 4'(ROUNDS - 1);
            state <= q_data.dec ? S_DEC : S_EMIT;
          end
        end
        S_DEC: begin
          if (rcnt == 4'd0) state <= S_EMIT;
          else rcnt <= rcnt - 4'd1;
        end
        S_EMIT: begin
          if (slot) begin
            result_valid <= 1'b1;
            if (rem != 5'd0) begin
              rem <= rem - 5'd1;
              idx <= idx + 4'd1;
            end else begin
              hx <= 1'b0;
            end
            if (fin) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!q_empty) begin
          data   <= q_data.data;
          cipher <= q_data.data;
          st     <= q_data.data ^ rk;
          dec    <= q_data.dec;
          xb     <= q_data.xb;
          last   <= q_data.last;
          if (q_data.restart) chain <= blk_t'({iv_high, iv_low});
        end
      end
      S_DEC: begin
        if (rcnt == 4'd0) begin
          data  <= inv_shift_sub(st) ^ rk ^ chain;
          chain <= cipher;
        end else begin
          st <= inv_mix(inv_shift_sub(st) ^ rk);
        end
      end
      S_EMIT: begin
        if (slot) result <= o_next;
      end
      default: ;
    endcase
  end

  `SADEC_ASSERT_NOW(a_pop_idle, pop, state == S_IDLE, "queue read outside idle")
  `SADEC_ASSERT_NOW(a_rcnt_range, state == S_DEC, rcnt <= 4'(ROUNDS - 1), "round count range")
  `SADEC_ASSERT_NEXT(a_dec_done, state == S_DEC && rcnt == 4'd0, state == S_EMIT,
                     "decrypt did not hand over to output")

endmodule

// ===== rtl/sample_aes_decryptor_unit.sv =====
// ----------------------------------------------------------------------------
// sample_aes_decryptor_unit
// Streaming SAMPLE-AES CBC frame decryptor, one frame byte per input beat.
//
// channel  dir  handshake                  payload
// item     in   item_valid / item_ready    in_t  (byte, frame flags, lengths)
// result   out  result_valid / result_ready out_t (byte, valid, last, dec)
// cfg      in   cfg_we                     cfg_index, cfg_data
//
// Clear bytes pass the back end as a fetch in idle and an output in emit; a
// decrypted block runs its inverse rounds in the decrypt state, then its bytes
// are output. A key-half write reloads the round-key table; item_ready stays
// low meanwhile. Reset runs the same key load for the zero key.
// The parser keeps taking beats while the queue has room and no key load runs.
// ----------------------------------------------------------------------------
module sample_aes_decryptor_unit
  import sadec_pkg::*;
#(
  parameter int VIDEO_LEAD  = VIDEO_LEAD_DEF,
  parameter int AUDIO_LEAD  = AUDIO_LEAD_DEF,
  parameter int CLEAR_RUN   = CLEAR_RUN_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_t         item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_t        result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic        key_valid;
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic        key_busy, key_start;
  logic        acc, push, pop, q_full, q_empty;
  q_t          entry, q_data;
  logic [3:0]  rk_idx;
  blk_t        rk;

  assign item_ready = !q_full && !key_busy;
  assign acc        = item_valid && item_ready;
  assign key_start  = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
      key_high  <= '0;
      key_low   <= '0;
      iv_high   <= '0;
      iv_low    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_VALID: key_valid <= cfg_data[0];
        REG_KEY_HIGH:  key_high  <= cfg_data;
        REG_KEY_LOW:   key_low   <= cfg_data;
        REG_IV_HIGH:   iv_high   <= cfg_data;
        REG_IV_LOW:    iv_low    <= cfg_data;
        default: ;
      endcase
    end
  end

  sadec_keys u_keys (
    .clk      (clk),
    .rst      (rst),
    .start    (key_start),
    .key_high (key_high),
    .key_low  (key_low),
    .rd_idx   (rk_idx),
    .rd_key   (rk),
    .busy     (key_busy)
  );

  sadec_front #(
    .VIDEO_LEAD (VIDEO_LEAD),
    .AUDIO_LEAD (AUDIO_LEAD),
    .CLEAR_RUN  (CLEAR_RUN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .item      (item),
    .key_valid (key_valid),
    .push      (push),
    .entry     (entry)
  );

  sadec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (entry),
    .pop   (pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  sadec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .pop          (pop),
    .iv_high      (iv_high),
    .iv_low       (iv_low),
    .rk_idx       (rk_idx),
    .rk           (rk),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ===== tb/sample_aes_decryptor_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sample AES decryptor testbench
// Feeds video and audio frames byte by byte, clear and encrypted, checks every
// output beat against an in-bench CBC decrypt model, with random idling.
// ----------------------------------------------------------------------------
module sample_aes_decryptor_unit_tb;
  import sadec_pkg::*;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  in_t         item;
  logic        result_valid;
  logic        result_ready;
  out_t        result;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  sample_aes_decryptor_unit u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // model state
  logic [7:0]  sb [256];
  logic [7:0]  isb [256];
  logic [7:0]  rk [176];
  logic [7:0]  chain [16];
  logic [7:0]  held [16];
  logic        kv;
  logic [63:0] kh, kl, ivh, ivl;
  int          pos, pat, nheld, zrun, lead;
  logic        enc, aud;

  out_t expected_q[$];
  int   mismatches = 0;
  int   beats_out = 0;
  int   cycles = 0;
  int   frames_enc = 0;

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  task automatic make_sbox();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 0;
      if (x != 0) begin
        inv = 1;
        for (int k = 0; k < 254; k++) inv = gmul(inv, 8'(x));
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sb[x] = s;
      isb[s] = 8'(x);
    end
  endtask

  task automatic expand_round_keys();
    logic [7:0] t[4];
    logic [7:0] f, rc;
    rc = 1;
    for (int i = 0; i < 8; i++) begin
      rk[i] = kh[63-8*i -: 8];
      rk[8+i] = kl[63-8*i -: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        f = t[0];
        t[0] = sb[t[1]] ^ rc; t[1] = sb[t[2]]; t[2] = sb[t[3]]; t[3] = sb[f];
        rc = gmul(rc, 2);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ t[j];
    end
  endtask

  task automatic cbc_block();
    logic [7:0] s[16], t[16], c[16];
    logic [7:0] a0, a1, a2, a3;
    for (int k = 0; k < 16; k++) begin
      c[k] = held[k];
      s[k] = held[k] ^ rk[160+k];
    end
    for (int r = 9; r >= 0; r--) begin
      for (int cc = 0; cc < 4; cc++)
        for (int rr = 0; rr < 4; rr++) t[rr+4*cc] = isb[s[rr+4*((cc-rr+4)%4)]];
      for (int k = 0; k < 16; k++) s[k] = t[k] ^ rk[16*r+k];
      if (r > 0) begin
        for (int cc = 0; cc < 4; cc++) begin
          a0 = s[4*cc]; a1 = s[4*cc+1]; a2 = s[4*cc+2]; a3 = s[4*cc+3];
          s[4*cc]   = gmul(a0,14) ^ gmul(a1,11) ^ gmul(a2,13) ^ gmul(a3,9);
          s[4*cc+1] = gmul(a0,9) ^ gmul(a1,14) ^ gmul(a2,11) ^ gmul(a3,13);
          s[4*cc+2] = gmul(a0,13) ^ gmul(a1,9) ^ gmul(a2,14) ^ gmul(a3,11);
          s[4*cc+3] = gmul(a0,11) ^ gmul(a1,13) ^ gmul(a2,9) ^ gmul(a3,14);
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      held[k] = s[k] ^ chain[k];
      chain[k] = c[k];
    end
  endtask

  task automatic push_out(logic [7:0] b, logic v, logic d);
    out_t o;
    o.out_byte = b; o.out_valid = v; o.out_last = 1'b0; o.was_decrypted = d;
    expected_q.push_back(o);
  endtask

  task automatic flush_held(logic d);
    for (int k = 0; k < nheld && k < 16; k++) push_out(held[k], 1'b1, d);
    nheld = 0;
  endtask

  task automatic predict_beat(in_t it);
    int   n0;
    logic keep;
    n0 = expected_q.size();
    if (it.first_byte) begin
      aud = it.frame_kind;
      lead = aud ? int'(it.header_size) + 16 : 32;
      enc = kv && (aud || it.frame_length > 48);
      if (enc) frames_enc++;
      for (int i = 0; i < 8; i++) begin
        chain[i] = ivh[63-8*i -: 8];
        chain[8+i] = ivl[63-8*i -: 8];
      end
      pos = 0; pat = 0; nheld = 0; zrun = 0;
    end
    if (!enc) push_out(it.data_byte, 1'b1, 1'b0);
    else begin
      keep = 1'b1;
      if (!aud) begin
        if (zrun == 2 && it.data_byte == ESC_BYTE) begin
          keep = 1'b0; zrun = 0;
        end else if (it.data_byte == ZERO_BYTE) begin
          if (zrun < 2) zrun++;
        end else zrun = 0;
      end
      if (keep) begin
        if (pos < lead) begin
          push_out(it.data_byte, 1'b1, 1'b0);
          pos++;
        end else if (aud) begin
          held[nheld % 16] = it.data_byte;
          nheld++;
          if (nheld >= 16) begin
            cbc_block(); flush_held(1'b1);
          end
        end else if (pat == 0) begin
          if (nheld < 16) begin
            held[nheld] = it.data_byte; nheld++;
          end else begin
            cbc_block(); flush_held(1'b1);
            push_out(it.data_byte, 1'b1, 1'b0);
            pat = 1;
          end
        end else begin
          push_out(it.data_byte, 1'b1, 1'b0);
          pat++;
          if (pat >= 144) pat = 0;
        end
      end
    end
    if (it.last_byte) begin
      if (enc) flush_held(1'b0);
      nheld = 0;
      enc = 1'b0;
      if (expected_q.size() == n0) push_out(8'h00, 1'b0, 1'b0);
      expected_q[expected_q.size()-1].out_last = 1'b1;
    end
  endtask

  // stimulus list of beats
  in_t stim_q[$];

  task automatic add_beat(logic [7:0] b, logic f, logic l, logic k, logic [3:0] h,
                          logic [15:0] len);
    in_t it;
    it.data_byte = b; it.first_byte = f; it.last_byte = l;
    it.frame_kind = k; it.header_size = h; it.frame_length = len;
    stim_q.push_back(it);
  endtask

  task automatic add_frame(int nbytes, logic k, logic [3:0] h, int esc_pct);
    logic [7:0] b;
    logic [15:0] len;
    len = (nbytes > 0) ? 16'(nbytes) : 16'd1;
    if ($urandom_range(0, 9) == 0) len = 16'($urandom_range(1, 65535));
    for (int i = 0; i < nbytes; i++) begin
      b = 8'($urandom);
      if ($urandom_range(0, 99) < esc_pct) b = ($urandom_range(0, 2) == 0) ? ESC_BYTE : ZERO_BYTE;
      add_beat(b, i == 0, i == nbytes - 1, k, h, len);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_KEY_VALID: kv = v[0];
      REG_KEY_HIGH: begin kh = v; expand_round_keys(); end
      REG_KEY_LOW: begin kl = v; expand_round_keys(); end
      REG_IV_HIGH: ivh = v;
      REG_IV_LOW: ivl = v;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_all();
    in_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      repeat ($urandom_range(0, 19)) @(negedge clk);
      item = it;
      item_valid = 1'b1;
      while (!item_ready) @(negedge clk);
      @(posedge clk);
      predict_beat(it);
      @(negedge clk);
      item_valid = 1'b0;
    end
  endtask

  // output side: pick a stall per beat, drop ready while stalling
  int   stall_left;
  int   stall_draw;
  logic took = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (took) begin
      stall_draw = $urandom_range(0, 19);
      result_ready <= (stall_draw == 0);
      stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst) cycles <= cycles + 1;
    took <= !rst && result_valid && result_ready;
    if (!rst && result_valid && result_ready) begin
      beats_out <= beats_out + 1;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", result);
      end else begin
        e = expected_q.pop_front();
        if (result.out_byte !== e.out_byte || result.out_valid !== e.out_valid ||
            result.out_last !== e.out_last || result.was_decrypted !== e.was_decrypted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp byte %h v%b l%b d%b, got byte %h v%b l%b d%b",
                     beats_out, e.out_byte, e.out_valid, e.out_last, e.was_decrypted,
                     result.out_byte, result.out_valid, result.out_last,
                     result.was_decrypted);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_we = 1'b0; cfg_index = REG_KEY_VALID; cfg_data = '0;
    make_sbox();
    kv = 0; kh = 0; kl = 0; ivh = 0; ivl = 0;
    expand_round_keys();
    pos = 0; pat = 0; nheld = 0; zrun = 0; lead = 32; enc = 0; aud = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (20) @(negedge clk);

    // directed: pass-through with key invalid, extreme bytes, stray bytes
    add_beat(8'h00, 1'b1, 1'b0, 1'b0, 4'h0, 16'd1);
    add_beat(8'hff, 1'b0, 1'b1, 1'b1, 4'hf, 16'hffff);
    add_beat(8'h5a, 1'b0, 1'b0, 1'b0, 4'h0, 16'd1);
    add_beat(8'ha5, 1'b0, 1'b1, 1'b0, 4'h0, 16'd1);
    send_all();
    settle();

    write_reg(REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_KEY_LOW, 64'h0);
    write_reg(REG_IV_HIGH, 64'h0);
    write_reg(REG_IV_LOW, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_KEY_VALID, 64'h1);
    write_reg(3'd7, 64'h1234);
    settle();

    // directed: audio with header, audio frame cut short by a restart, short video
    add_frame(40, 1'b1, 4'd7, 0);
    add_beat(8'h00, 1'b1, 1'b0, 1'b1, 4'd0, 16'd1);
    for (int i = 0; i < 20; i++) add_beat(8'($urandom), 1'b0, 1'b0, 1'b1, 4'd0, 16'd1);
    add_beat(8'h11, 1'b1, 1'b1, 1'b0, 4'd0, 16'd1);
    send_all();
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(REG_KEY_HIGH, {$urandom, $urandom});
      write_reg(REG_KEY_LOW, {$urandom, $urandom});
      write_reg(REG_IV_HIGH, {$urandom, $urandom});
      write_reg(REG_IV_LOW, {$urandom, $urandom});
      write_reg(REG_KEY_VALID, 64'(ph != 2));
      settle();
      case ($urandom_range(0, 4))
        0: add_frame($urandom_range(49, 90), 1'b0, 4'd0, 30);
        1: add_frame($urandom_range(49, 100), 1'b0, 4'd0, 5);
        2: add_frame($urandom_range(1, 60), 1'b1, 4'($urandom), 0);
        3: add_frame($urandom_range(1, 48), 1'b0, 4'd0, 20);
        default: begin
          add_beat(8'($urandom), 1'b0, 1'($urandom), 1'($urandom), 4'($urandom),
                   16'($urandom));
          add_frame($urandom_range(17, 50), 1'b1, 4'd9, 0);
        end
      endcase
      send_all();
      settle();
    end

    $display("%0d output beats checked, %0d encrypted frames, %0d cycles",
             beats_out, frames_enc, cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
